@@ hdl/utf8s_pkg.sv @@
package utf8s_pkg;

    localparam int BYTE_W      = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int WIN_DEPTH   = 4;
    localparam int WIDX_W      = $clog2(WIN_DEPTH);
    localparam int WCNT_W      = $clog2(WIN_DEPTH + 1);

    localparam logic [BYTE_W-1:0] REPLACE_BYTE = 8'h3F;

    // Class of one byte as a start or continuation byte
    typedef enum logic [2:0] {
        KIND_ASCII,
        KIND_LEAD2,
        KIND_LEAD3,
        KIND_LEAD4,
        KIND_CONT,
        KIND_BAD
    } kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        kind_t             kind;
        logic              last;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        kind_t             kind;
    } win_t;

endpackage

@@ hdl/utf8_sanitizer.sv @@
// Channel  | Ports                               | Payload
// ---------+-------------------------------------+--------------------------------
// input    | s_tvalid s_tready s_tdata s_tlast   | raw byte, last byte of string
// result   | m_tvalid m_tready m_tdata m_tlast   | sanitised byte, last of string
//
// The front classifies each byte on its transfer and queues it (four entries), so input
// transfers continue while the back works. The back loads one queued byte into its window,
// decides one front byte per cycle while the result is free to take it, and parks an
// unfinished sequence in the window until the next queued byte is loaded.
// Reset (aresetn low at a clock edge) empties the queue, the window and the output.
// A stalled result holds the scan; the front keeps taking transfers until the queue fills.
module utf8_sanitizer (
    input  logic       aclk,
    input  logic       aresetn,
    // input channel
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // is_last
    // result channel
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // out_last
);

    // queue between the classifying front and the scanning back
    logic             q_valid;
    logic             q_pop;
    utf8s_pkg::item_t q_item;

    // accept and classify: every byte is tagged ASCII, lead of length 2..4,
    // continuation or invalid start, then queued with its end-of-string flag
    utf8s_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // scan the window: pass whole clean sequences, replace bad starts with '?',
    // rescan after a bad continuation, hold an unfinished sequence for the next
    // byte, and drop it behind one '?' when the string ends
    utf8s_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ hdl/utf8s_front.sv @@
module utf8s_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tlast,
    output logic                  q_valid,
    output utf8s_pkg::item_t      q_item,
    input  logic                  q_pop
);

    localparam logic [utf8s_pkg::QPTR_W:0] FULL_COUNT = (utf8s_pkg::QPTR_W + 1)'(
        utf8s_pkg::QUEUE_DEPTH);

    utf8s_pkg::item_t              mem_reg [utf8s_pkg::QUEUE_DEPTH];
    logic [utf8s_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [utf8s_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [utf8s_pkg::QPTR_W:0]    count_reg, count_next;
    utf8s_pkg::kind_t              kind;
    logic                          push;
    logic                          pop;

    // Classify the incoming byte by its top bits
    always_comb begin
        if (s_tdata[7] == 1'b0) begin
            kind = utf8s_pkg::KIND_ASCII;
        end else if ((s_tdata & 8'hC0) == 8'h80) begin
            kind = utf8s_pkg::KIND_CONT;
        end else if ((s_tdata & 8'hE0) == 8'hC0) begin
            kind = utf8s_pkg::KIND_LEAD2;
        end else if ((s_tdata & 8'hF0) == 8'hE0) begin
            kind = utf8s_pkg::KIND_LEAD3;
        end else if ((s_tdata & 8'hF8) == 8'hF0) begin
            kind = utf8s_pkg::KIND_LEAD4;
        end else begin
            kind = utf8s_pkg::KIND_BAD;
        end
    end

    assign s_tready = (count_reg != FULL_COUNT);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= '{data: s_tdata, kind: kind, last: s_tlast};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_COUNT)
        else $error("queue count beyond depth");

    a_full_no_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == FULL_COUNT && !q_pop) |=> count_reg == FULL_COUNT)
        else $error("full queue changed without a pop");

    a_pop_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop did not lower the count");

endmodule

@@ hdl/utf8s_back.sv @@
module utf8s_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  utf8s_pkg::item_t      q_item,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic                  m_tlast
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t                        state_reg, state_next;
    utf8s_pkg::win_t               win_reg [utf8s_pkg::WIN_DEPTH];
    utf8s_pkg::win_t               win_next [utf8s_pkg::WIN_DEPTH];
    logic [utf8s_pkg::WCNT_W-1:0]  cnt_reg, cnt_next;
    logic [1:0]                    run_reg, run_next;
    logic                          last_reg, last_next;
    logic                          out_valid_reg, out_valid_next;
    logic [7:0]                    out_data_reg, out_data_next;
    logic                          out_last_reg, out_last_next;

    logic                          out_free;
    logic                          emit;
    logic [7:0]                    emit_data;
    logic                          shift;
    logic                          clear;
    logic                          hold;
    logic [utf8s_pkg::WCNT_W-1:0]  seq_len;
    logic                          seq_ok;
    logic [utf8s_pkg::WCNT_W-1:0]  cnt_after;

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;

    // Length announced by the lead at the front and whether its tail is clean
    always_comb begin
        case (win_reg[0].kind)
            utf8s_pkg::KIND_LEAD2: begin
                seq_len = utf8s_pkg::WCNT_W'(2);
                seq_ok  = (win_reg[1].kind == utf8s_pkg::KIND_CONT);
            end
            utf8s_pkg::KIND_LEAD3: begin
                seq_len = utf8s_pkg::WCNT_W'(3);
                seq_ok  = (win_reg[1].kind == utf8s_pkg::KIND_CONT)
                       && (win_reg[2].kind == utf8s_pkg::KIND_CONT);
            end
            utf8s_pkg::KIND_LEAD4: begin
                seq_len = utf8s_pkg::WCNT_W'(4);
                seq_ok  = (win_reg[1].kind == utf8s_pkg::KIND_CONT)
                       && (win_reg[2].kind == utf8s_pkg::KIND_CONT)
                       && (win_reg[3].kind == utf8s_pkg::KIND_CONT);
            end
            default: begin
                seq_len = utf8s_pkg::WCNT_W'(1);
                seq_ok  = 1'b1;
            end
        endcase
    end

    // One front byte decided per cycle while the result is free
    always_comb begin
        emit      = 1'b0;
        emit_data = win_reg[0].data;
        shift     = 1'b0;
        clear     = 1'b0;
        hold      = 1'b0;
        run_next  = run_reg;
        if (state_reg == ST_SCAN && out_free) begin
            if (run_reg != 2'd0) begin
                emit     = 1'b1;
                shift    = 1'b1;
                run_next = run_reg - 1'b1;
            end else begin
                case (win_reg[0].kind)
                    utf8s_pkg::KIND_ASCII: begin
                        emit  = 1'b1;
                        shift = 1'b1;
                    end
                    utf8s_pkg::KIND_LEAD2,
                    utf8s_pkg::KIND_LEAD3,
                    utf8s_pkg::KIND_LEAD4: begin
                        if (cnt_reg < seq_len) begin
                            // string ends inside the sequence: one '?' and drop the rest
                            if (last_reg) begin
                                emit      = 1'b1;
                                emit_data = utf8s_pkg::REPLACE_BYTE;
                                clear     = 1'b1;
                            end else begin
                                hold = 1'b1;
                            end
                        end else if (seq_ok) begin
                            emit     = 1'b1;
                            shift    = 1'b1;
                            run_next = 2'(seq_len - 1'b1);
                        end else begin
                            // rescan from the byte after the lead
                            emit      = 1'b1;
                            emit_data = utf8s_pkg::REPLACE_BYTE;
                            shift     = 1'b1;
                        end
                    end
                    default: begin
                        emit      = 1'b1;
                        emit_data = utf8s_pkg::REPLACE_BYTE;
                        shift     = 1'b1;
                    end
                endcase
            end
        end
    end

    always_comb begin
        if (clear) begin
            cnt_after = '0;
        end else if (shift) begin
            cnt_after = cnt_reg - 1'b1;
        end else begin
            cnt_after = cnt_reg;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        for (int i = 0; i < utf8s_pkg::WIN_DEPTH; i++) begin
            win_next[i] = win_reg[i];
        end

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    win_next[cnt_reg[utf8s_pkg::WIDX_W-1:0]] =
                        '{data: q_item.data, kind: q_item.kind};
                    cnt_next   = cnt_reg + 1'b1;
                    last_next  = q_item.last;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (shift) begin
                    for (int i = 0; i < utf8s_pkg::WIN_DEPTH - 1; i++) begin
                        win_next[i] = win_reg[i + 1];
                    end
                end
                cnt_next = cnt_after;
                if (emit) begin
                    out_valid_next = 1'b1;
                    out_data_next  = emit_data;
                    out_last_next  = last_reg && (cnt_after == '0);
                end
                if (hold || ((emit) && cnt_after == '0)) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < utf8s_pkg::WIN_DEPTH; i++) begin
            win_reg[i] <= win_next[i];
        end
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            run_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_idle_window: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> cnt_reg < utf8s_pkg::WCNT_W'(utf8s_pkg::WIN_DEPTH))
        else $error("idle with a full window");

    a_run_covered: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg != 2'd0 |-> (state_reg == ST_SCAN && cnt_reg >= {1'b0, run_reg}))
        else $error("sequence run longer than the window");

    a_last_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && last_reg && cnt_after == '0) |=> (cnt_reg == '0 && state_reg == ST_IDLE))
        else $error("window not empty after end of string");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && out_valid_reg && !m_tready)
            |=> $stable(cnt_reg) && $stable(run_reg))
        else $error("scan moved while the result stalled");

endmodule
